// ===== rtl/core/stg_pkg.sv =====
// ============================================================================
// stg_pkg: shared types, constants and functions of the sine tone generator
// Holds the quarter-wave sine table contents, configuration decoding helpers
// and the structs that travel between the lookup and serializer units.
// ============================================================================
package stg_pkg;

    // Sizing
    localparam int MAX_CHANNELS    = 8;
    localparam int PHASE_BITS      = 32;
    localparam int TABLE_ADDR_BITS = 10;

    // Fixed field widths
    localparam int STEP_W      = 32;
    localparam int CHCFG_W     = 4;
    localparam int BITSCFG_W   = 6;
    localparam int CHAN_IDX_W  = 3;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // Sample format
    localparam int BITS_MIN    = 8;
    localparam int BITS_MAX    = 32;
    localparam int WORD_W      = BITS_MAX;
    localparam int BPS_W       = 3;
    localparam int BSEL_W      = 2;
    localparam int SAMPLE_W    = 16;
    localparam int SAMPLE_FRAC = SAMPLE_W - 1;
    localparam int MAXV_W      = BITS_MAX - 2;
    localparam int MULT_W      = SAMPLE_W + MAXV_W;

    // Channel counters
    localparam int CHAN_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CHCNT_W = $clog2(MAX_CHANNELS + 1);

    // Quarter-wave table geometry
    localparam int TBL_N     = 1 << TABLE_ADDR_BITS;
    localparam int TBL_DEPTH = TBL_N + 1;
    localparam int TBL_AW    = TABLE_ADDR_BITS + 1;

    // Series constants for the table build
    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] SINE_FULL   = 64'd32767;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BITS   = 2'd2;

    // Configuration reset values
    localparam logic [STEP_W-1:0]    RST_PHASE_STEP    = '0;
    localparam logic [CHCFG_W-1:0]   RST_CHANNEL_COUNT = 4'd2;
    localparam logic [BITSCFG_W-1:0] RST_SAMPLE_BITS   = 6'd16;

    typedef struct packed {
        logic [STEP_W-1:0]    phase_step;
        logic [CHCFG_W-1:0]   channel_count;
        logic [BITSCFG_W-1:0] sample_bits;
    } cfg_t;

    // One looked-up frame handed to the serializer
    typedef struct packed {
        logic                  mode;
        logic                  neg;
        logic [MAXV_W-1:0]     mag;
        logic [PHASE_BITS-1:0] phase;
    } frame_t;

    typedef logic [SAMPLE_W-1:0] sine_tbl_t [TBL_DEPTH];

    // Build the Q1.15 quarter-wave sine by the truncating Horner series
    function automatic sine_tbl_t build_sine_tbl();
        sine_tbl_t   tbl;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] q;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] e;
        for (int k = 0; k < TBL_DEPTH; k++)
        begin
            x    = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
            x2   = (x * x) >> 30;
            term = Q30_ONE;
            for (int j = 0; j < 6; j++)
            begin
                q = (x2 * term) >> 30;
                // Divide by (2n)(2n+1), highest order first
                case (j)
                    0:       p = q / 64'd156;
                    1:       p = q / 64'd110;
                    2:       p = q / 64'd72;
                    3:       p = q / 64'd42;
                    4:       p = q / 64'd20;
                    default: p = q / 64'd6;
                endcase
                term = (p > Q30_ONE) ? 64'd0 : Q30_ONE - p;
            end
            s = (x * term) >> 30;
            e = (s * SINE_FULL + (Q30_ONE >> 1)) >> 30;
            if (e > SINE_FULL)
            begin
                e = SINE_FULL;
            end
            tbl[k] = SAMPLE_W'(e);
        end
        return tbl;
    endfunction

    localparam sine_tbl_t SINE_TBL = build_sine_tbl();

    // Clamp the sample width to the supported range
    function automatic logic [BITSCFG_W-1:0] clamp_bits(input logic [BITSCFG_W-1:0] b);
        logic [BITSCFG_W-1:0] r;
        r = b;
        if (b < BITSCFG_W'(BITS_MIN))
        begin
            r = BITSCFG_W'(BITS_MIN);
        end
        else if (b > BITSCFG_W'(BITS_MAX))
        begin
            r = BITSCFG_W'(BITS_MAX);
        end
        return r;
    endfunction

    function automatic logic [BPS_W-1:0] bytes_per_sample(input logic [BITSCFG_W-1:0] b);
        logic [BITSCFG_W-1:0] cb;
        cb = clamp_bits(b);
        return cb[BITSCFG_W-1:3];
    endfunction

    // Full-scale amplitude 2^(bits-2) - 1
    function automatic logic [MAXV_W-1:0] max_value(input logic [BITSCFG_W-1:0] b);
        logic [BITSCFG_W-1:0] cb;
        logic [MAXV_W:0]      one_sh;
        cb     = clamp_bits(b);
        one_sh = (MAXV_W + 1)'(1) << (cb - BITSCFG_W'(2));
        return MAXV_W'(one_sh - (MAXV_W + 1)'(1));
    endfunction

    // Zero counts as one channel, saturate at the maximum
    function automatic logic [CHCNT_W-1:0] clamp_chans(input logic [CHCFG_W-1:0] c);
        logic [CHCNT_W-1:0] r;
        if (c == '0)
        begin
            r = CHCNT_W'(1);
        end
        else if (int'(c) > MAX_CHANNELS)
        begin
            r = CHCNT_W'(MAX_CHANNELS);
        end
        else
        begin
            r = CHCNT_W'(c);
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/stg_ram.sv =====
// ============================================================================
// stg_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module stg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/stg_lookup.sv =====
// ============================================================================
// stg_lookup: phase accumulator and sine lookup
// Loads the quarter-wave table into RAM after reset, steps or loads the phase,
// reads the table and scales the sample to the configured amplitude.
// ============================================================================
module stg_lookup (
    input  logic                             clk,
    input  logic                             rst_n,
    input  stg_pkg::cfg_t                    cfg,
    input  logic                             take,
    input  logic                             mode,
    input  logic [stg_pkg::PHASE_BITS-1:0]   phase_in,
    input  logic                             sink_free,
    output logic                             ready,
    output logic                             filling,
    output logic                             frame_valid,
    output stg_pkg::frame_t                  frame
);

    import stg_pkg::*;

    logic                  filling_reg, filling_next;
    logic [TBL_AW-1:0]     fill_cnt_reg, fill_cnt_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;

    logic                  b_valid_reg, b_valid_next;
    logic                  b_mode_reg, b_mode_next;
    logic                  b_neg_reg, b_neg_next;
    logic [PHASE_BITS-1:0] b_phase_reg, b_phase_next;

    logic                  c_valid_reg, c_valid_next;
    frame_t                c_frame_reg, c_frame_next;

    logic [1:0]            quad;
    logic [TABLE_ADDR_BITS-1:0] idx;
    logic [TBL_AW-1:0]     raddr;
    logic [SAMPLE_W-1:0]   rdata;
    logic [PHASE_BITS-1:0] phase_adv;
    logic [MULT_W-1:0]     prod;
    logic                  b_ready;
    logic                  c_ready;

    // Split the phase into quadrant and table index, mirror odd quadrants
    assign quad      = phase_reg[PHASE_BITS-1 -: 2];
    assign idx       = phase_reg[PHASE_BITS-3 -: TABLE_ADDR_BITS];
    assign raddr     = quad[0] ? (TBL_AW'(TBL_N) - {1'b0, idx}) : {1'b0, idx};
    assign phase_adv = phase_reg + PHASE_BITS'(cfg.phase_step);

    // Pipeline flow control
    assign c_ready = !c_valid_reg || sink_free;
    assign b_ready = !b_valid_reg || c_ready;
    assign ready   = !filling_reg && b_ready;

    stg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TBL_DEPTH)
    ) u_sine_ram (
        .clk   (clk),
        .we    (filling_reg),
        .waddr (fill_cnt_reg),
        .wdata (SINE_TBL[fill_cnt_reg]),
        .re    (take),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Scale the table sample to the amplitude
    assign prod = MULT_W'(rdata) * MULT_W'(max_value(cfg.sample_bits));

    always_comb
    begin
        filling_next  = filling_reg;
        fill_cnt_next = fill_cnt_reg;
        phase_next    = phase_reg;
        b_valid_next  = b_valid_reg;
        b_mode_next   = b_mode_reg;
        b_neg_next    = b_neg_reg;
        b_phase_next  = b_phase_reg;
        c_valid_next  = c_valid_reg;
        c_frame_next  = c_frame_reg;

        // Sweep the table into RAM
        if (filling_reg)
        begin
            if (fill_cnt_reg == TBL_AW'(TBL_N))
            begin
                filling_next = 1'b0;
            end
            else
            begin
                fill_cnt_next = fill_cnt_reg + TBL_AW'(1);
            end
        end

        // Advance or load the phase on each accepted request
        if (b_ready)
        begin
            b_valid_next = take;
        end
        if (take)
        begin
            b_mode_next = mode;
            b_neg_next  = quad[1];
            if (mode)
            begin
                phase_next   = phase_in;
                b_phase_next = phase_in;
            end
            else
            begin
                phase_next   = phase_adv;
                b_phase_next = phase_adv;
            end
        end

        // Hold the scaled magnitude for the serializer
        if (c_ready)
        begin
            c_valid_next = b_valid_reg;
            if (b_valid_reg)
            begin
                c_frame_next.mode  = b_mode_reg;
                c_frame_next.neg   = b_neg_reg;
                c_frame_next.mag   = prod[SAMPLE_FRAC +: MAXV_W];
                c_frame_next.phase = b_phase_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filling_reg  <= 1'b1;
            fill_cnt_reg <= '0;
            phase_reg    <= '0;
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
        end
        else
        begin
            filling_reg  <= filling_next;
            fill_cnt_reg <= fill_cnt_next;
            phase_reg    <= phase_next;
            b_valid_reg  <= b_valid_next;
            c_valid_reg  <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_mode_reg  <= b_mode_next;
        b_neg_reg   <= b_neg_next;
        b_phase_reg <= b_phase_next;
        c_frame_reg <= c_frame_next;
    end

    assign filling     = filling_reg;
    assign frame_valid = c_valid_reg;
    assign frame       = c_frame_reg;

endmodule

// ===== rtl/core/stg_serializer.sv =====
// ============================================================================
// stg_serializer: PCM byte serializer
// Expands a generate frame into little-endian bytes for every channel, a
// phase-load frame into one zero byte, and drives the output register.
// ============================================================================
module stg_serializer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  stg_pkg::cfg_t                    cfg,
    input  logic                             frame_valid,
    input  stg_pkg::frame_t                  frame,
    output logic                             free,
    input  logic                             out_stall,
    output logic                             out_valid,
    output logic [stg_pkg::BYTE_W-1:0]       data_byte,
    output logic [stg_pkg::CHAN_IDX_W-1:0]   channel_index,
    output logic                             last_of_frame,
    output logic [stg_pkg::PHASE_BITS-1:0]   phase_out
);

    import stg_pkg::*;

    logic                  s_valid_reg, s_valid_next;
    logic                  s_mode_reg, s_mode_next;
    logic [WORD_W-1:0]     sample_latch_reg, sample_latch_next;
    logic [PHASE_BITS-1:0] s_phase_reg, s_phase_next;
    logic [BSEL_W-1:0]     s_byte_reg, s_byte_next;
    logic [CHAN_W-1:0]     s_chan_reg, s_chan_next;

    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]     data_byte_reg, data_byte_next;
    logic [CHAN_IDX_W-1:0] chan_idx_reg, chan_idx_next;
    logic                  last_reg, last_next;
    logic [PHASE_BITS-1:0] phase_out_reg, phase_out_next;

    logic [BPS_W-1:0]      bps;
    logic [CHCNT_W-1:0]    chans;
    logic                  last_byte;
    logic                  last_chan;
    logic                  s_last;
    logic                  o_ready;
    logic                  emit;
    logic [WORD_W-1:0]     mag_word;
    logic [BYTE_W-1:0]     byte_sel;

    assign bps       = bytes_per_sample(cfg.sample_bits);
    assign chans     = clamp_chans(cfg.channel_count);
    assign last_byte = (BPS_W'(s_byte_reg) + BPS_W'(1)) == bps;
    assign last_chan = (CHCNT_W'(s_chan_reg) + CHCNT_W'(1)) == chans;
    assign s_last    = s_mode_reg || (last_byte && last_chan);

    // Handshake between serializer, output register and lookup
    assign o_ready = !out_valid_reg || !out_stall;
    assign emit    = s_valid_reg && o_ready;
    assign free    = !s_valid_reg || (emit && s_last);

    // Pick the current byte; the first byte of a sample is zero
    assign byte_sel = BYTE_W'(sample_latch_reg >> {s_byte_reg, 3'b000});
    assign mag_word = {{(WORD_W - MAXV_W){1'b0}}, frame.mag};

    always_comb
    begin
        s_valid_next      = s_valid_reg;
        s_mode_next       = s_mode_reg;
        sample_latch_next = sample_latch_reg;
        s_phase_next      = s_phase_reg;
        s_byte_next       = s_byte_reg;
        s_chan_next       = s_chan_reg;
        out_valid_next    = out_valid_reg;
        data_byte_next    = data_byte_reg;
        chan_idx_next     = chan_idx_reg;
        last_next         = last_reg;
        phase_out_next    = phase_out_reg;

        // Drop the output once taken, load the next byte
        if (o_ready)
        begin
            out_valid_next = emit;
        end
        if (emit)
        begin
            data_byte_next = (s_mode_reg || s_byte_reg == '0) ? '0 : byte_sel;
            chan_idx_next  = CHAN_IDX_W'(s_chan_reg);
            last_next      = s_last;
            phase_out_next = s_phase_reg;
            if (s_last)
            begin
                s_valid_next = 1'b0;
            end
            else if (last_byte)
            begin
                s_byte_next = '0;
                s_chan_next = s_chan_reg + CHAN_W'(1);
            end
            else
            begin
                s_byte_next = s_byte_reg + BSEL_W'(1);
            end
        end

        // Take the next frame and apply the sign
        if (free && frame_valid)
        begin
            s_valid_next      = 1'b1;
            s_mode_next       = frame.mode;
            s_phase_next      = frame.phase;
            s_byte_next       = '0;
            s_chan_next       = '0;
            if (!frame.mode)
            begin
                sample_latch_next = frame.neg ? (WORD_W'(0) - mag_word) : mag_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg      <= 1'b0;
            s_byte_reg       <= '0;
            s_chan_reg       <= '0;
            sample_latch_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            s_valid_reg      <= s_valid_next;
            s_byte_reg       <= s_byte_next;
            s_chan_reg       <= s_chan_next;
            sample_latch_reg <= sample_latch_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_mode_reg    <= s_mode_next;
        s_phase_reg   <= s_phase_next;
        data_byte_reg <= data_byte_next;
        chan_idx_reg  <= chan_idx_next;
        last_reg      <= last_next;
        phase_out_reg <= phase_out_next;
    end

    assign out_valid     = out_valid_reg;
    assign data_byte     = data_byte_reg;
    assign channel_index = chan_idx_reg;
    assign last_of_frame = last_reg;
    assign phase_out     = phase_out_reg;

endmodule

// ===== rtl/core/sine_tone_pcm_generator.sv =====
// ============================================================================
// sine_tone_pcm_generator: direct digital synthesis sine tone generator
// Pipeline: phase/table read register, scaling register, serializer latch,
// output register. Throughput: one output byte per cycle while out_stall is
// low; a generate request yields channel_count * sample_bits/8 bytes and a
// phase load one byte. Requests are accepted while earlier bytes drain, as
// long as the lookup stages have room. Reset: configuration returns to its
// defaults and the sine table RAM is loaded, during which in_stall stays high.
// ============================================================================
module sine_tone_pcm_generator (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [stg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stg_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input requests
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             mode,
    input  logic [stg_pkg::PHASE_BITS-1:0]   phase_in,
    // Output bytes
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [stg_pkg::BYTE_W-1:0]       data_byte,
    output logic [stg_pkg::CHAN_IDX_W-1:0]   channel_index,
    output logic                             last_of_frame,
    output logic [stg_pkg::PHASE_BITS-1:0]   phase_out
);

    import stg_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    frame_t frame;
    logic   frame_valid;
    logic   sink_free;
    logic   lk_ready;
    logic   filling;
    logic   take;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PHASE_STEP:    cfg_next.phase_step    = STEP_W'(cfg_data);
                CFG_CHANNEL_COUNT: cfg_next.channel_count = CHCFG_W'(cfg_data);
                CFG_SAMPLE_BITS:   cfg_next.sample_bits   = BITSCFG_W'(cfg_data);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step    <= RST_PHASE_STEP;
            cfg_reg.channel_count <= RST_CHANNEL_COUNT;
            cfg_reg.sample_bits   <= RST_SAMPLE_BITS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input handshake
    assign in_stall = !lk_ready;
    assign take     = in_valid && lk_ready;

    stg_lookup u_lookup (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .take        (take),
        .mode        (mode),
        .phase_in    (phase_in),
        .sink_free   (sink_free),
        .ready       (lk_ready),
        .filling     (filling),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    stg_serializer u_serializer (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .frame_valid   (frame_valid),
        .frame         (frame),
        .free          (sink_free),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .data_byte     (data_byte),
        .channel_index (channel_index),
        .last_of_frame (last_of_frame),
        .phase_out     (phase_out)
    );

    // No request is taken while the table is being loaded
    a_stall_while_filling: assert property (
        @(posedge clk) disable iff (!rst_n)
        filling |-> in_stall
    ) else $error("request accepted during table load");

    // Nothing reaches the output before the table is loaded
    a_quiet_while_filling: assert property (
        @(posedge clk) disable iff (!rst_n)
        filling |-> !out_valid
    ) else $error("output byte during table load");

    // A frame's bytes follow each other without a gap
    a_frame_contiguous: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_frame) |=> out_valid
    ) else $error("gap inside a frame");

endmodule
